>>> src/kt_pkg.sv
// shared types, constants and helpers for the key table block
package kt_pkg;

  // built table depth, id length, config width and reset value of the entries-in-use register
  localparam int unsigned TableDepth = 64;
  localparam int unsigned IdBytes    = 8;
  localparam int unsigned CfgW       = 7;
  localparam logic [CfgW-1:0] EntriesRst = 7'd64;

  // request kinds
  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_READ  = 1'b1
  } req_e;

  // result codes
  typedef enum logic [1:0] {
    OC_OK      = 2'd0,
    OC_FULL    = 2'd1,
    OC_MISSING = 2'd2
  } outcome_e;

  // request word
  typedef struct packed {
    req_e        req_type;
    logic [63:0] client_ident;
    logic [63:0] server_ident;
    logic [7:0]  entry_state;
    logic [31:0] key_ident;
    logic [63:0] key_bits;
  } in_t;

  // response word
  typedef struct packed {
    outcome_e    outcome;
    logic [7:0]  found_state;
    logic [31:0] found_key_ident;
    logic [63:0] found_key_bits;
  } out_t;

  // one table entry
  typedef struct packed {
    logic [63:0] client;
    logic [63:0] server;
    logic [63:0] key;
    logic [7:0]  ent_state;
    logic [31:0] key_ident;
  } entry_t;

  // compare unit flags for the entry under test
  typedef struct packed {
    logic hit;
    logic free;
  } cmp_t;

  // zero-terminated id: clear bytes at and after the first zero byte
  function automatic logic [63:0] norm_id(logic [63:0] v);
    logic [63:0] r;
    logic        live;
    r    = '0;
    live = 1'b1;
    for (int b = 0; b < 8; b++) begin
      if (b >= int'(IdBytes) || v[8*b +: 8] == 8'h00) begin
        live = 1'b0;
      end
      if (live) begin
        r[8*b +: 8] = v[8*b +: 8];
      end
    end
    return r;
  endfunction

endpackage

>>> src/key_table_upsert_lookup_top.sv
// top level of the session key table with insert/update and lookup
// Session key table holding TABLE_DEPTH entries of client id, server id, status, key id and
// key. After reset the table runs a clearing pass, one entry per cycle, and takes no request
// until it ends; config writes are taken throughout. Each request scans entries 0 to N-1
// (N = entries_in_use capped at TABLE_DEPTH) through the single read port of the entry
// memory, one entry per cycle into one shared compare unit, and stops at the first id pair
// match. The next request is accepted only after the scan and response step of the last one,
// sooner on an early match. The response word sits in an output register, so a stalled
// response does not hold off the next request. Ids are zero terminated: bytes from the first
// zero byte on are cleared first.
module key_table_upsert_lookup_top #(
  parameter int unsigned TABLE_DEPTH = kt_pkg::TableDepth
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  kt_pkg::in_t             in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output kt_pkg::out_t            out_data_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [kt_pkg::CfgW-1:0] cfg_data_i
);

  localparam int unsigned AddrW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  kt_pkg::entry_t   mem_wdata;
  logic [AddrW-1:0] mem_raddr;
  kt_pkg::entry_t   mem_rdata;
  logic [63:0]      cid;
  logic [63:0]      sid;
  kt_pkg::cmp_t     cmp;

  // sequencer
  kt_ctrl #(
    .TableDepth (TABLE_DEPTH),
    .AddrW      (AddrW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .cid_o       (cid),
    .sid_o       (sid),
    .cmp_i       (cmp)
  );

  // entry memory
  kt_store #(
    .TableDepth (TABLE_DEPTH),
    .AddrW      (AddrW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // shared compare unit
  kt_match u_match (
    .entry_i (mem_rdata),
    .cid_i   (cid),
    .sid_i   (sid),
    .cmp_o   (cmp)
  );

endmodule

>>> src/kt_store.sv
// entry memory with one write port and one registered read port
module kt_store #(
  parameter int unsigned TableDepth = kt_pkg::TableDepth,
  parameter int unsigned AddrW      = (TableDepth > 1) ? $clog2(TableDepth) : 1
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrW-1:0]     waddr_i,
  input  kt_pkg::entry_t       wdata_i,
  input  logic [AddrW-1:0]     raddr_i,
  output kt_pkg::entry_t       rdata_o
);

  kt_pkg::entry_t mem_q [TableDepth];
  kt_pkg::entry_t rdata_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/kt_match.sv
// compare unit: id pair match and free-entry test on the word read back
module kt_match (
  input  kt_pkg::entry_t entry_i,
  input  logic [63:0]    cid_i,
  input  logic [63:0]    sid_i,
  output kt_pkg::cmp_t   cmp_o
);

  // id pair equality and all-zero entry
  always_comb begin
    cmp_o.hit  = (entry_i.client == cid_i) && (entry_i.server == sid_i);
    cmp_o.free = (entry_i == '0);
  end

endmodule

>>> src/kt_ctrl.sv
// scan sequencer: clear pass, entry scan, table update and response register
module kt_ctrl #(
  parameter int unsigned TableDepth = kt_pkg::TableDepth,
  parameter int unsigned AddrW      = (TableDepth > 1) ? $clog2(TableDepth) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  kt_pkg::in_t           in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output kt_pkg::out_t          out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [kt_pkg::CfgW-1:0] cfg_data_i,
  output logic                  mem_we_o,
  output logic [AddrW-1:0]      mem_waddr_o,
  output kt_pkg::entry_t        mem_wdata_o,
  output logic [AddrW-1:0]      mem_raddr_o,
  input  kt_pkg::entry_t        mem_rdata_i,
  output logic [63:0]           cid_o,
  output logic [63:0]           sid_o,
  input  kt_pkg::cmp_t          cmp_i
);

  localparam int unsigned CntW = $clog2(TableDepth + 1);
  localparam int unsigned LimW = (CntW > kt_pkg::CfgW) ? CntW : kt_pkg::CfgW;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_RESP
  } state_e;

  state_e                  state_q, state_d;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic [CntW-1:0]         lim_q, lim_d;
  logic                    pend_q, pend_d;
  logic [AddrW-1:0]        pend_idx_q, pend_idx_d;
  logic                    free_vld_q, free_vld_d;
  logic [AddrW-1:0]        free_idx_q, free_idx_d;
  kt_pkg::in_t             req_q, req_d;
  kt_pkg::out_t            res_q, res_d;
  logic                    out_valid_q, out_valid_d;
  kt_pkg::out_t            out_q, out_d;
  logic [kt_pkg::CfgW-1:0] cfg_q, cfg_d;
  logic                    in_acc;
  logic [LimW-1:0]         cfg_ext;
  logic [LimW-1:0]         depth_ext;
  logic [LimW-1:0]         lim_ext;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cid_o       = req_q.client_ident;
  assign sid_o       = req_q.server_ident;
  assign mem_raddr_o = cnt_q[AddrW-1:0];

  // scan limit: register value capped at the built depth
  assign cfg_ext   = LimW'(cfg_q);
  assign depth_ext = LimW'(TableDepth);
  assign lim_ext   = (cfg_ext > depth_ext) ? depth_ext : cfg_ext;

  // sequencer next state
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    lim_d       = lim_q;
    pend_d      = pend_q;
    pend_idx_d  = pend_idx_q;
    free_vld_d  = free_vld_q;
    free_idx_d  = free_idx_q;
    req_d       = req_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    cfg_d       = cfg_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = cnt_q[AddrW-1:0];
    mem_wdata_o = '0;

    // config write
    if (cfg_valid_i && cfg_ready_o) begin
      cfg_d = cfg_data_i;
    end

    // response word taken
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        mem_we_o = 1'b1;
        if (cnt_q == CntW'(TableDepth - 1)) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      ST_IDLE: begin
        if (in_acc) begin
          req_d              = in_data_i;
          req_d.client_ident = kt_pkg::norm_id(in_data_i.client_ident);
          req_d.server_ident = kt_pkg::norm_id(in_data_i.server_ident);
          lim_d              = CntW'(lim_ext);
          cnt_d              = '0;
          pend_d             = 1'b0;
          free_vld_d         = 1'b0;
          state_d            = ST_SCAN;
        end
      end

      ST_SCAN: begin
        if (pend_q && cmp_i.hit) begin
          // id pair found
          res_d = '0;
          res_d.outcome = kt_pkg::OC_OK;
          if (req_q.req_type == kt_pkg::REQ_READ) begin
            res_d.found_state     = mem_rdata_i.ent_state;
            res_d.found_key_ident = mem_rdata_i.key_ident;
            res_d.found_key_bits  = mem_rdata_i.key;
          end else begin
            mem_we_o    = 1'b1;
            mem_waddr_o = pend_idx_q;
            mem_wdata_o = '{client:    req_q.client_ident,
                            server:    req_q.server_ident,
                            key:       req_q.key_bits,
                            ent_state: req_q.entry_state,
                            key_ident: req_q.key_ident};
          end
          cnt_d      = '0;
          pend_d     = 1'b0;
          free_vld_d = 1'b0;
          state_d    = ST_RESP;
        end else begin
          // remember the first free entry
          if (pend_q && cmp_i.free && !free_vld_q) begin
            free_vld_d = 1'b1;
            free_idx_d = pend_idx_q;
          end
          if (cnt_q < lim_q) begin
            pend_d     = 1'b1;
            pend_idx_d = cnt_q[AddrW-1:0];
            cnt_d      = cnt_q + 1'b1;
          end else if (pend_q) begin
            pend_d = 1'b0;
          end else begin
            // scan done without a match
            res_d = '0;
            if (req_q.req_type == kt_pkg::REQ_READ) begin
              res_d.outcome = kt_pkg::OC_MISSING;
            end else if (free_vld_q) begin
              res_d.outcome = kt_pkg::OC_OK;
              mem_we_o    = 1'b1;
              mem_waddr_o = free_idx_q;
              mem_wdata_o = '{client:    req_q.client_ident,
                              server:    req_q.server_ident,
                              key:       req_q.key_bits,
                              ent_state: req_q.entry_state,
                              key_ident: req_q.key_ident};
            end else begin
              res_d.outcome = kt_pkg::OC_FULL;
            end
            cnt_d      = '0;
            free_vld_d = 1'b0;
            state_d    = ST_RESP;
          end
        end
      end

      ST_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      lim_q       <= '0;
      pend_q      <= 1'b0;
      pend_idx_q  <= '0;
      free_vld_q  <= 1'b0;
      free_idx_q  <= '0;
      req_q       <= '0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      cfg_q       <= kt_pkg::EntriesRst;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      lim_q       <= lim_d;
      pend_q      <= pend_d;
      pend_idx_q  <= pend_idx_d;
      free_vld_q  <= free_vld_d;
      free_idx_q  <= free_idx_d;
      req_q       <= req_d;
      res_q       <= res_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
      cfg_q       <= cfg_d;
    end
  end

`ifndef NO_ASSERTIONS
  // table writes only from the clear pass or the end of a scan
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we_o |-> (state_q == ST_CLEAR || state_q == ST_SCAN))
    else $error("table write outside clear pass or scan end");

  // a pending compare always refers to an entry inside the scan limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && pend_q) |-> (CntW'(pend_idx_q) < lim_q))
    else $error("compare beyond scan limit");

  // an accepted request starts a scan in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_SCAN))
    else $error("accepted request did not start a scan");

  // only a successful read carries entry data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.outcome != kt_pkg::OC_OK) |->
      (out_q.found_state == '0 && out_q.found_key_ident == '0 &&
       out_q.found_key_bits == '0))
    else $error("entry data on a failed request");

  // not found is a read outcome only
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RESP && res_q.outcome == kt_pkg::OC_MISSING) |->
      (req_q.req_type == kt_pkg::REQ_READ))
    else $error("not found reported for a write");
`endif

endmodule

>>> bench/tb_key_table_upsert_lookup_top.sv
// self-checking bench for the session key table: directed and random requests against a mirror
`timescale 1ns / 1ps

module tb_key_table_upsert_lookup_top;
  import kt_pkg::*;

  // receiver stall patterns
  typedef enum int {
    RX_FREE,
    RX_RANDOM,
    RX_PERIODIC
  } rx_mode_e;

  localparam int HoldCycles = 400;
  localparam int PhaseWords = 150;
  localparam int DrainTail  = 80;

  // mirror of the table contents, predicts each reply in request order
  class key_table_mirror;
    logic [63:0]  client_tab [TableDepth];
    logic [63:0]  server_tab [TableDepth];
    logic [63:0]  key_tab [TableDepth];
    logic [7:0]   state_tab [TableDepth];
    logic [31:0]  kid_tab [TableDepth];
    logic [CfgW-1:0] entries;
    out_t         due_replies [$];
    int           errors;

    function new();
      for (int i = 0; i < TableDepth; i++) begin
        client_tab[i] = '0;
        server_tab[i] = '0;
        key_tab[i]    = '0;
        state_tab[i]  = '0;
        kid_tab[i]    = '0;
      end
      entries = EntriesRst;
      errors  = 0;
    endfunction

    function void set_entries(logic [CfgW-1:0] v);
      entries = v;
    endfunction

    function int pending();
      return due_replies.size();
    endfunction

    // keep the leading non-zero characters, at most IdBytes of them
    function logic [63:0] trim_id(logic [63:0] v);
      logic [63:0] r;
      int          b;
      r = '0;
      b = 0;
      while (b < 8 && b < int'(IdBytes) && v[8*b +: 8] != 8'h00) begin
        r[8*b +: 8] = v[8*b +: 8];
        b++;
      end
      return r;
    endfunction

    // apply one accepted request and queue the reply it must produce
    function void take_request(in_t w);
      out_t        res;
      int          limit;
      int          hit;
      logic [63:0] cid;
      logic [63:0] sid;
      limit = (entries > TableDepth) ? int'(TableDepth) : int'(entries);
      cid   = trim_id(w.client_ident);
      sid   = trim_id(w.server_ident);
      hit   = -1;
      res   = '0;
      for (int i = 0; i < limit && hit < 0; i++) begin
        if (client_tab[i] == cid && server_tab[i] == sid) hit = i;
      end
      if (w.req_type == REQ_WRITE) begin
        // no id match: take the first entry that is all zero
        for (int i = 0; i < limit && hit < 0; i++) begin
          if (client_tab[i] == '0 && server_tab[i] == '0 && key_tab[i] == '0 &&
              state_tab[i] == '0 && kid_tab[i] == '0) hit = i;
        end
        if (hit < 0) begin
          res.outcome = OC_FULL;
        end else begin
          client_tab[hit] = cid;
          server_tab[hit] = sid;
          key_tab[hit]    = w.key_bits;
          state_tab[hit]  = w.entry_state;
          kid_tab[hit]    = w.key_ident;
          res.outcome     = OC_OK;
        end
      end else if (hit < 0) begin
        res.outcome = OC_MISSING;
      end else begin
        res.outcome         = OC_OK;
        res.found_state     = state_tab[hit];
        res.found_key_ident = kid_tab[hit];
        res.found_key_bits  = key_tab[hit];
      end
      due_replies.push_back(res);
    endfunction

    function void flag(string what, logic [63:0] want, logic [63:0] got);
      errors++;
      $error("%s: expected %h, got %h", what, want, got);
    endfunction

    // compare one accepted reply word with the oldest prediction
    function void check_reply(out_t got);
      out_t want;
      if (due_replies.size() == 0) begin
        errors++;
        $error("reply word with nothing outstanding: %h", got);
        return;
      end
      want = due_replies.pop_front();
      if (got.outcome !== want.outcome)
        flag("outcome", 64'(want.outcome), 64'(got.outcome));
      if (got.found_state !== want.found_state)
        flag("found_state", 64'(want.found_state), 64'(got.found_state));
      if (got.found_key_ident !== want.found_key_ident)
        flag("found_key_ident", 64'(want.found_key_ident), 64'(got.found_key_ident));
      if (got.found_key_bits !== want.found_key_bits)
        flag("found_key_bits", want.found_key_bits, got.found_key_bits);
    endfunction
  endclass

  logic            clk_i;
  logic            rst_ni;
  logic            in_valid;
  logic            in_stall;
  in_t             in_data;
  logic            out_valid;
  logic            out_stall;
  out_t            out_data;
  logic            cfg_valid;
  logic            cfg_ready;
  logic [CfgW-1:0] cfg_data;

  key_table_mirror mirror;
  bit              rx_hold_req;
  logic [63:0]     client_pool [12];
  logic [63:0]     server_pool [6];

  key_table_upsert_lookup_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  // 4 ns clock
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // hard stop
  initial begin
    #4_000_000;
    $display("** key_table_upsert_lookup_top: FAILED **");
    $finish;
  end

  // reply checking
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) mirror.check_reply(out_data);
  end

  // receiver stall generator, with an occasional long hold-off on request
  initial begin : rx_stall_gen
    rx_mode_e mode;
    int       span;
    int       hold_left;
    int       tick;
    int       period;
    out_stall <= 1'b0;
    mode      = RX_FREE;
    span      = 0;
    hold_left = 0;
    tick      = 0;
    period    = 3;
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold_left   = HoldCycles;
      end
      if (span == 0) begin
        mode   = rx_mode_e'($urandom_range(0, 2));
        span   = $urandom_range(30, 300);
        period = $urandom_range(2, 6);
      end
      span--;
      tick++;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (mode)
          RX_FREE:   out_stall <= 1'b0;
          RX_RANDOM: out_stall <= ($urandom_range(0, 3) == 0);
          default:   out_stall <= (tick % period == 0);
        endcase
      end
    end
  end

  // offer one request word and hold it until accepted
  task automatic send_request(input in_t w);
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk_i); while (in_stall);
    mirror.take_request(w);
  endtask

  task automatic wait_drained();
    while (mirror.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_entries(input logic [CfgW-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    mirror.set_entries(v);
  endtask

  function automatic in_t req(req_e kind, logic [63:0] cid, logic [63:0] sid,
                              logic [7:0] st, logic [31:0] kid, logic [63:0] key);
    in_t w;
    w.req_type     = kind;
    w.client_ident = cid;
    w.server_ident = sid;
    w.entry_state  = st;
    w.key_ident    = kid;
    w.key_bits     = key;
    return w;
  endfunction

  // fill the bytes past the terminator with junk, which must not matter
  function automatic logic [63:0] smear_id(logic [63:0] v);
    logic past_end;
    past_end = 1'b0;
    for (int b = 0; b < 8; b++) begin
      if (past_end) v[8*b +: 8] = 8'($urandom_range(0, 255));
      else if (v[8*b +: 8] == 8'h00) past_end = 1'b1;
    end
    return v;
  endfunction

  function automatic logic [63:0] pool_id();
    logic [63:0] v;
    int          len;
    v   = '0;
    len = $urandom_range(1, 8);
    for (int b = 0; b < len; b++) v[8*b +: 8] = 8'($urandom_range(1, 255));
    return v;
  endfunction

  // mostly known id pairs so entries get hit, updated and filled up
  function automatic in_t make_request();
    in_t w;
    int  pick;
    pick = $urandom_range(0, 99);
    w.req_type    = $urandom_range(0, 1) ? REQ_READ : REQ_WRITE;
    w.entry_state = 8'($urandom_range(0, 255));
    w.key_ident   = $urandom;
    w.key_bits    = {$urandom, $urandom};
    if (pick < 10) begin
      w.client_ident = {$urandom, $urandom};
      w.server_ident = {$urandom, $urandom};
    end else if (pick < 14) begin
      w.client_ident = smear_id(64'h0);
      w.server_ident = $urandom_range(0, 1) ? smear_id(64'h0) : 64'h0;
    end else begin
      w.client_ident = client_pool[$urandom_range(0, 11)];
      w.server_ident = server_pool[$urandom_range(0, 5)];
      if ($urandom_range(0, 2) == 0) w.client_ident = smear_id(w.client_ident);
      if ($urandom_range(0, 2) == 0) w.server_ident = smear_id(w.server_ident);
    end
    if ($urandom_range(0, 9) == 0) begin
      w.entry_state = '0;
      w.key_ident   = '0;
      w.key_bits    = '0;
    end
    return w;
  endfunction

  // random words in bursts with gaps, now and then waiting for all replies
  task automatic run_random(input int count);
    int sent;
    int burst;
    int gap;
    bit drain;
    sent = 0;
    while (sent < count) begin
      burst = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      for (int k = 0; k < burst && sent < count; k++) begin
        send_request(make_request());
        sent++;
      end
      gap   = $urandom_range(0, 6);
      drain = ($urandom_range(0, 39) == 0);
      if (drain && gap == 0) gap = 1;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
        if (drain) wait_drained();
      end
    end
    in_valid <= 1'b0;
  endtask

  // directed cases on the empty table with the full scan
  task automatic run_directed();
    logic [63:0] id_a;
    logic [63:0] id_b;
    logic [63:0] ones;
    id_a = 64'h0000_0065_6369_6C61;
    id_b = 64'h0000_0000_3176_7273;
    ones = '1;
    send_request(req(REQ_READ, id_a, id_b, 8'h11, 32'h1, 64'h1));
    send_request(req(REQ_READ, 64'h0, 64'h0, 8'h0, 32'h0, 64'h0));
    send_request(req(REQ_WRITE, id_a, id_b, 8'hFF, 32'hFFFF_FFFF, ones));
    send_request(req(REQ_READ, 64'hDEAD_0065_6369_6C61, id_b, 8'h0, 32'h0, 64'h0));
    send_request(req(REQ_WRITE, id_a, 64'h1234_5600_3176_7273, 8'h5A, 32'h1234_5678,
                     64'h0123_4567_89AB_CDEF));
    send_request(req(REQ_READ, id_a, id_b, 8'hFF, 32'hFFFF_FFFF, ones));
    send_request(req(REQ_WRITE, ones, ones, 8'h0, 32'h0, 64'h0));
    send_request(req(REQ_READ, ones, ones, 8'h0, 32'h0, 64'h0));
    // empty id pair lands on the first free entry and keeps it free
    send_request(req(REQ_WRITE, 64'h0, 64'h0, 8'h0, 32'h0, 64'h0));
    // id starting with a zero byte is empty, so this fills that same entry
    send_request(req(REQ_WRITE, 64'hFFFF_FFFF_FFFF_FF00, 64'h0, 8'hA5, 32'hCAFE_F00D,
                     64'h8000_0000_0000_0001));
    send_request(req(REQ_READ, 64'h0, 64'h0, 8'h0, 32'h0, 64'h0));
    send_request(req(REQ_WRITE, id_b, id_a, 8'h3C, 32'h0BAD_BEEF, 64'h5555_AAAA_5555_AAAA));
    send_request(req(REQ_READ, id_b, id_a, 8'h0, 32'h0, 64'h0));
    send_request(req(REQ_READ, id_a, 64'h0, 8'h0, 32'h0, 64'h0));
    send_request(req(REQ_READ, 64'h0, id_b, 8'h0, 32'h0, 64'h0));
    send_request(req(REQ_WRITE, 64'h0102_0304_0506_0708, 64'h8070_6050_4030_2010, 8'h80,
                     32'h8000_0001, 64'hFEDC_BA98_7654_3210));
    send_request(req(REQ_READ, 64'h0102_0304_0506_0708, 64'h8070_6050_4030_2010, 8'h0,
                     32'h0, 64'h0));
    send_request(req(REQ_WRITE, id_a, id_b, 8'h0, 32'h0, 64'h0));
    send_request(req(REQ_READ, id_a, id_b, 8'h0, 32'h0, 64'h0));
    // zero data over the empty pair frees that entry again
    send_request(req(REQ_WRITE, 64'h0, 64'h0, 8'h0, 32'h0, 64'h0));
    send_request(req(REQ_READ, 64'h0, 64'h0, 8'h0, 32'h0, 64'h0));
  endtask

  // main sequence
  initial begin
    logic [CfgW-1:0] setting;
    mirror      = new();
    rx_hold_req = 1'b0;
    rst_ni    <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= EntriesRst;
    for (int i = 0; i < 12; i++) client_pool[i] = pool_id();
    for (int i = 0; i < 6; i++) server_pool[i] = pool_id();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset setting of the scan length
    run_directed();
    run_random(PhaseWords);
    wait_drained();

    // other scan lengths, extremes included
    for (int p = 0; p < 7; p++) begin
      case (p)
        0:       setting = 7'd4;
        1:       setting = 7'd0;
        2:       setting = 7'd1;
        3:       setting = 7'd127;
        4:       setting = 7'd16;
        5:       setting = 7'($urandom_range(2, 63));
        default: setting = 7'd64;
      endcase
      write_entries(setting);
      if (p == 3) begin
        // long receiver hold-off while words keep coming
        rx_hold_req = 1'b1;
        for (int k = 0; k < 24; k++) send_request(make_request());
      end
      run_random(PhaseWords);
      wait_drained();
    end

    repeat (DrainTail) @(posedge clk_i);
    if (mirror.errors == 0 && mirror.pending() == 0) begin
      $display("** key_table_upsert_lookup_top: PASSED **");
    end else begin
      $display("** key_table_upsert_lookup_top: FAILED **");
    end
    $finish;
  end

endmodule

>>> key_table_upsert_lookup_top.f
src/kt_pkg.sv
src/kt_store.sv
src/kt_match.sv
src/kt_ctrl.sv
src/key_table_upsert_lookup_top.sv
bench/tb_key_table_upsert_lookup_top.sv
